// File: src/mer_pkg.sv
// shared types and constants for the midpoint ellipse rasterizer
// no dependencies; imported by mer_ctrl, mer_datapath and the top level
package mer_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int RADIUS_BITS_DEF = 11;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_RX,
        ST_SQ_RY,
        ST_INIT_MUL,
        ST_INIT,
        ST_MUL_U,
        ST_MUL_V,
        ST_TEST,
        ST_SQ_T,
        ST_SEED_A,
        ST_SQ_V,
        ST_SEED_B,
        ST_RXRY,
        ST_SEED_END,
        ST_DELTA,
        ST_APPLY,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        MUL_RX_RX,
        MUL_RY_RY,
        MUL_RX2_V,
        MUL_RY2_U,
        MUL_T_T,
        MUL_RY2_P,
        MUL_VM1_SQ,
        MUL_RX2_P,
        MUL_RX2_RY2
    } mul_op_t;

    typedef struct packed {
        logic    load_start;
        mul_op_t mul_op;
        logic    ld_rx2;
        logic    ld_ry2;
        logic    init_dec;
        logic    cap_a;
        logic    cap_b;
        logic    seed_load;
        logic    seed_add;
        logic    seed_sub;
        logic    calc_delta;
        logic    apply;
        logic    emit;
    } dp_cmd_t;

    typedef struct packed {
        logic active;
        logic region_two;
        logic a_lt_b;
        logic out_free;
    } dp_status_t;

endpackage

// File: src/mer_ctrl.sv
// sequencer for the midpoint ellipse rasterizer
// depends on mer_pkg; drives mer_datapath through dp_cmd_t, reads dp_status_t
module mer_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_command,
    input  mer_pkg::dp_status_t status,
    output logic                in_ready,
    output mer_pkg::dp_cmd_t    cmd
);
    import mer_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_command == CMD_START)
                    begin
                        state_next = ST_SQ_RX;
                    end
                    else if (status.active)
                    begin
                        state_next = ST_MUL_U;
                    end
                end
            end
            ST_SQ_RX:    state_next = ST_SQ_RY;
            ST_SQ_RY:    state_next = ST_INIT_MUL;
            ST_INIT_MUL: state_next = ST_INIT;
            ST_INIT:     state_next = ST_EMIT;
            ST_MUL_U:    state_next = ST_MUL_V;
            ST_MUL_V:    state_next = ST_TEST;
            ST_TEST:
            begin
                if (!status.region_two && !status.a_lt_b)
                begin
                    state_next = ST_SQ_T;
                end
                else
                begin
                    state_next = ST_DELTA;
                end
            end
            ST_SQ_T:     state_next = ST_SEED_A;
            ST_SEED_A:   state_next = ST_SQ_V;
            ST_SQ_V:     state_next = ST_SEED_B;
            ST_SEED_B:   state_next = ST_RXRY;
            ST_RXRY:     state_next = ST_SEED_END;
            ST_SEED_END: state_next = ST_DELTA;
            ST_DELTA:    state_next = ST_APPLY;
            ST_APPLY:    state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.mul_op = MUL_RX2_RY2;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.load_start = in_valid && (in_command == CMD_START);
            end
            ST_SQ_RX:
            begin
                cmd.mul_op = MUL_RX_RX;
            end
            ST_SQ_RY:
            begin
                cmd.ld_rx2 = 1'b1;
                cmd.mul_op = MUL_RY_RY;
            end
            ST_INIT_MUL:
            begin
                cmd.ld_ry2 = 1'b1;
                cmd.mul_op = MUL_RX2_V;
            end
            ST_INIT:
            begin
                cmd.init_dec = 1'b1;
            end
            ST_MUL_U:
            begin
                cmd.mul_op = MUL_RY2_U;
            end
            ST_MUL_V:
            begin
                cmd.cap_a  = 1'b1;
                cmd.mul_op = MUL_RX2_V;
            end
            ST_TEST:
            begin
                cmd.cap_b = 1'b1;
            end
            ST_SQ_T:
            begin
                cmd.mul_op = MUL_T_T;
            end
            ST_SEED_A:
            begin
                cmd.mul_op = MUL_RY2_P;
            end
            ST_SQ_V:
            begin
                cmd.seed_load = 1'b1;
                cmd.mul_op    = MUL_VM1_SQ;
            end
            ST_SEED_B:
            begin
                cmd.mul_op = MUL_RX2_P;
            end
            ST_RXRY:
            begin
                cmd.seed_add = 1'b1;
                cmd.mul_op   = MUL_RX2_RY2;
            end
            ST_SEED_END:
            begin
                cmd.seed_sub = 1'b1;
            end
            ST_DELTA:
            begin
                cmd.calc_delta = 1'b1;
            end
            ST_APPLY:
            begin
                cmd.apply = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: src/mer_datapath.sv
// ellipse state, shared multiplier, decision update and output register
// depends on mer_pkg; controlled by mer_ctrl
module mer_datapath #(
    parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
    localparam int IN_DATA_W  = ((2 * COORD_BITS + 2 * RADIUS_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((8 * (COORD_BITS + 2) + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_DATA_W-1:0]   in_data,
    input  mer_pkg::dp_cmd_t       cmd,
    output mer_pkg::dp_status_t    status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_DATA_W-1:0]  out_data,
    output logic                   out_last
);
    import mer_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int R     = RADIUS_BITS;
    localparam int U_W   = R + 1;
    localparam int SQ_W  = 2 * R;
    localparam int MB_W  = SQ_W + 2;
    localparam int P_W   = SQ_W + MB_W;
    localparam int A_W   = SQ_W + U_W;
    localparam int DEC_W = 4 * R + 4;
    localparam int OUT_W = C + 2;
    localparam int SUM_W = ((C > U_W) ? C : U_W) + 2;

    logic [C-1:0]            cx_reg;
    logic [C-1:0]            cy_reg;
    logic [R-1:0]            rx_reg;
    logic [SQ_W-1:0]         rx2_reg;
    logic [SQ_W-1:0]         ry2_reg;
    logic [U_W-1:0]          u_reg;
    logic [R-1:0]            v_reg;
    logic signed [DEC_W-1:0] dec_reg;
    logic signed [DEC_W-1:0] delta_reg;
    logic [A_W-1:0]          a_reg;
    logic [A_W-1:0]          b_reg;
    logic [P_W-1:0]          p_reg;
    logic                    region_two_reg;
    logic                    active_reg;
    logic                    out_valid_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic                    out_last_reg;

    logic [SQ_W-1:0]         mul_a;
    logic [MB_W-1:0]         mul_b;
    logic [P_W-1:0]          mul_p;
    logic [R+1:0]            t_val;
    logic [R-1:0]            vm1;
    logic signed [DEC_W-1:0] rx2_d;
    logic signed [DEC_W-1:0] ry2_d;
    logic signed [DEC_W-1:0] p_d;
    logic signed [DEC_W-1:0] a_d;
    logic signed [DEC_W-1:0] b_d;
    logic signed [DEC_W-1:0] delta_next;
    logic                    dec_neg;
    logic                    out_free;
    logic [SUM_W-1:0]        cx_s;
    logic [SUM_W-1:0]        cy_s;
    logic [SUM_W-1:0]        u_s;
    logic [SUM_W-1:0]        v_s;
    logic [SUM_W-1:0]        x_plus;
    logic [SUM_W-1:0]        x_minus;
    logic [SUM_W-1:0]        y_plus;
    logic [SUM_W-1:0]        y_minus;
    logic [8*OUT_W-1:0]      pts;

    assign t_val = {u_reg, 1'b1};
    assign vm1   = v_reg - R'(1);

    always_comb
    begin
        case (cmd.mul_op)
            MUL_RX_RX:
            begin
                mul_a = SQ_W'(rx_reg);
                mul_b = MB_W'(rx_reg);
            end
            MUL_RY_RY:
            begin
                mul_a = SQ_W'(v_reg);
                mul_b = MB_W'(v_reg);
            end
            MUL_RX2_V:
            begin
                mul_a = rx2_reg;
                mul_b = MB_W'(v_reg);
            end
            MUL_RY2_U:
            begin
                mul_a = ry2_reg;
                mul_b = MB_W'(u_reg);
            end
            MUL_T_T:
            begin
                mul_a = SQ_W'(t_val);
                mul_b = MB_W'(t_val);
            end
            MUL_RY2_P:
            begin
                mul_a = ry2_reg;
                mul_b = p_reg[MB_W-1:0];
            end
            MUL_VM1_SQ:
            begin
                mul_a = SQ_W'(vm1);
                mul_b = MB_W'(vm1);
            end
            MUL_RX2_P:
            begin
                mul_a = rx2_reg;
                mul_b = p_reg[MB_W-1:0];
            end
            MUL_RX2_RY2:
            begin
                mul_a = rx2_reg;
                mul_b = MB_W'(ry2_reg);
            end
            default:
            begin
                mul_a = rx2_reg;
                mul_b = MB_W'(ry2_reg);
            end
        endcase
    end

    assign mul_p = P_W'(mul_a) * P_W'(mul_b);

    assign rx2_d   = DEC_W'(rx2_reg);
    assign ry2_d   = DEC_W'(ry2_reg);
    assign p_d     = DEC_W'(p_reg);
    assign a_d     = DEC_W'(a_reg);
    assign b_d     = DEC_W'(b_reg);
    assign dec_neg = dec_reg[DEC_W-1];

    // decision increments, scaled by four
    always_comb
    begin
        if (!region_two_reg)
        begin
            if (dec_neg)
            begin
                delta_next = (a_d <<< 3) + (ry2_d <<< 3) + (ry2_d <<< 2);
            end
            else
            begin
                delta_next = (a_d <<< 3) - (b_d <<< 3) + (rx2_d <<< 3)
                           + (ry2_d <<< 3) + (ry2_d <<< 2);
            end
        end
        else
        begin
            if (dec_neg)
            begin
                delta_next = (a_d <<< 3) - (b_d <<< 3) + (ry2_d <<< 3)
                           + (rx2_d <<< 3) + (rx2_d <<< 2);
            end
            else
            begin
                delta_next = (rx2_d <<< 3) + (rx2_d <<< 2) - (b_d <<< 3);
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    assign cx_s    = SUM_W'(cx_reg);
    assign cy_s    = SUM_W'(cy_reg);
    assign u_s     = SUM_W'(u_reg);
    assign v_s     = SUM_W'(v_reg);
    assign x_plus  = cx_s + u_s;
    assign x_minus = cx_s - u_s;
    assign y_plus  = cy_s + v_s;
    assign y_minus = cy_s - v_s;

    // pt0 .. pt3, x then y, lowest first
    assign pts = {y_plus[OUT_W-1:0],  x_minus[OUT_W-1:0],
                  y_minus[OUT_W-1:0], x_minus[OUT_W-1:0],
                  y_minus[OUT_W-1:0], x_plus[OUT_W-1:0],
                  y_plus[OUT_W-1:0],  x_plus[OUT_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_two_reg <= 1'b0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load_start)
            begin
                region_two_reg <= 1'b0;
            end
            else if (cmd.seed_sub)
            begin
                region_two_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                active_reg    <= (v_reg != '0);
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= mul_p;
        if (cmd.load_start)
        begin
            cx_reg <= in_data[C-1:0];
            cy_reg <= in_data[2*C-1:C];
            rx_reg <= in_data[2*C+R-1:2*C];
            v_reg  <= in_data[2*C+2*R-1:2*C+R];
            u_reg  <= '0;
        end
        if (cmd.ld_rx2)
        begin
            rx2_reg <= p_reg[SQ_W-1:0];
        end
        if (cmd.ld_ry2)
        begin
            ry2_reg <= p_reg[SQ_W-1:0];
        end
        if (cmd.cap_a)
        begin
            a_reg <= p_reg[A_W-1:0];
        end
        if (cmd.cap_b)
        begin
            b_reg <= p_reg[A_W-1:0];
        end
        if (cmd.calc_delta)
        begin
            delta_reg <= delta_next;
        end
        if (cmd.init_dec)
        begin
            dec_reg <= (ry2_d <<< 2) + rx2_d - (p_d <<< 2);
        end
        else if (cmd.seed_load)
        begin
            dec_reg <= p_d;
        end
        else if (cmd.seed_add)
        begin
            dec_reg <= dec_reg + (p_d <<< 2);
        end
        else if (cmd.seed_sub)
        begin
            dec_reg <= dec_reg - (p_d <<< 2);
        end
        else if (cmd.apply)
        begin
            dec_reg <= dec_reg + delta_reg;
        end
        if (cmd.apply)
        begin
            if (!region_two_reg)
            begin
                u_reg <= u_reg + U_W'(1);
                if (!dec_neg)
                begin
                    v_reg <= v_reg - R'(1);
                end
            end
            else
            begin
                if (dec_neg)
                begin
                    u_reg <= u_reg + U_W'(1);
                end
                v_reg <= v_reg - R'(1);
            end
        end
        if (cmd.emit)
        begin
            out_data_reg <= OUT_DATA_W'(pts);
            out_last_reg <= (v_reg == '0);
        end
    end

    assign status.active     = active_reg;
    assign status.region_two = region_two_reg;
    assign status.a_lt_b     = a_reg < p_reg[A_W-1:0];
    assign status.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

// File: src/midpoint_ellipse_rasterizer.sv
// midpoint ellipse rasterizer top level: sequencer plus datapath
// depends on mer_pkg, mer_ctrl, mer_datapath
//
//  channel | dir | beat contents
//  s_*     | in  | tuser command, tdata center_x, center_y, radius_x, radius_y
//  m_*     | out | tdata pt0_x .. pt3_y, tlast last
//
// start beat: SQ_RX, SQ_RY, INIT_MUL, INIT, then EMIT;
// step beat: MUL_U, MUL_V, TEST, (SQ_T .. SEED_END on the beat that seeds region two),
// DELTA, APPLY, then EMIT; one shared 2R x (2R+2) multiplier serves every product
// a step with no ellipse in progress is accepted in idle and gives no beat
// one result register: the next beat is taken while a result waits,
// its own result waits in the sequencer until the register frees
// reset clears the sequencer, the output valid, the region flag and the in-progress flag
module midpoint_ellipse_rasterizer #(
    parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
    localparam int IN_DATA_W  = ((2 * COORD_BITS + 2 * RADIUS_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((8 * (COORD_BITS + 2) + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // center_x, center_y, radius_x, radius_y
    input  logic                  s_tuser,   // command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, ..., pt3_y
    output logic                  m_tlast
);
    import mer_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    mer_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_command (s_tuser),
        .status     (status),
        .in_ready   (s_tready),
        .cmd        (cmd)
    );

    mer_datapath #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
